/* rtl/core/ldsc_pkg.sv */
// ldsc_pkg: types, codes and constants shared by the LED dimmer sleep controller.
// No dependencies; imported by ldsc_step and led_dimmer_sleep_controller_top.
`default_nettype none

package ldsc_pkg;

  // Width of the press timer and the store countdown
  localparam int TIMER_W = 16;
  localparam logic [31:0] TIMER_MAX = 32'hFFFF_FFFF >> (32 - TIMER_W);

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Input transaction kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_STEP   = 2'd1;
  localparam logic [1:0] KIND_SWITCH = 2'd2;

  // Switch levels
  localparam logic SW_PRESSED  = 1'b0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURBO       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_FLOOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STORE_DELAY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LEVEL = 3'd6;

  // Register reset values
  localparam logic [7:0]  RST_MAX_LEVEL   = 8'd255;
  localparam logic [7:0]  RST_MIN_LEVEL   = 8'd0;
  localparam logic [8:0]  RST_TURBO       = 9'd128;
  localparam logic [15:0] RST_DEBOUNCE    = 16'd50;
  localparam logic [7:0]  RST_WAKE_FLOOR  = 8'd10;
  localparam logic [15:0] RST_STORE_DELAY = 16'd3500;
  localparam logic [7:0]  RST_START_LEVEL = 8'd128;

  // Level after reset: the larger of start level and wake floor
  localparam logic [7:0] RST_LEVEL =
      (RST_START_LEVEL < RST_WAKE_FLOOR) ? RST_WAKE_FLOOR : RST_START_LEVEL;

  typedef enum logic [1:0] {
    MODE_AWAKE  = 2'd0,
    MODE_ASLEEP = 2'd1,
    MODE_WAKING = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0]  max_level;
    logic [7:0]  min_level;
    logic [8:0]  turbo_threshold;
    logic [15:0] debounce_time;
    logic [7:0]  wake_floor_level;
    logic [15:0] store_delay_ms;
  } cfg_t;

  typedef struct packed {
    mode_t              mode;
    logic [7:0]         level;
    logic               press_active;
    logic [TIMER_W-1:0] press_elapsed;
    logic               release_ok;
    logic               store_pending;
    logic [TIMER_W-1:0] store_countdown;
  } state_t;

  typedef struct packed {
    logic [7:0] main_duty;
    logic       boost_enable;
    logic [7:0] boost_duty;
    logic       asleep;
    logic       store_strobe;
    logic [7:0] store_value;
  } res_t;

  // Store delay loaded into the countdown, saturated to the timer range
  function automatic logic [TIMER_W-1:0] load_delay(input logic [15:0] delay);
    logic [31:0] t;
    t = (32'(delay) > TIMER_MAX) ? TIMER_MAX : 32'(delay);
    return t[TIMER_W-1:0];
  endfunction

  localparam logic [TIMER_W-1:0] RST_COUNTDOWN =
      TIMER_W'((32'(RST_STORE_DELAY) > TIMER_MAX) ? TIMER_MAX : 32'(RST_STORE_DELAY));

endpackage

`default_nettype wire

/* rtl/core/ldsc_step.sv */
// ldsc_step: next-state and result logic for one transaction of the dimmer.
// Depends on ldsc_pkg for the state, configuration and result types.
`default_nettype none

module ldsc_step (
  input  ldsc_pkg::cfg_t     cfg,
  input  ldsc_pkg::state_t   st,
  input  logic [1:0]         kind,
  input  logic signed [7:0]  steps,
  input  logic               switch_level,
  output ldsc_pkg::state_t   st_nxt,
  output ldsc_pkg::res_t     res
);
  import ldsc_pkg::*;

  logic              strobe;
  logic signed [9:0] pos;
  logic [7:0]        nv;
  logic              long_press;
  logic              sleeping;
  logic              boost;

  always_comb begin
    st_nxt     = st;
    strobe     = 1'b0;
    pos        = $signed({2'b00, st.level}) + 10'(steps);
    long_press = st.press_active && (32'(st.press_elapsed) > 32'(cfg.debounce_time));

    // Clamp: above max takes max, below zero takes min
    if (pos > $signed({2'b00, cfg.max_level})) begin
      nv = cfg.max_level;
    end else if (pos[9]) begin
      nv = cfg.min_level;
    end else begin
      nv = pos[7:0];
    end

    unique case (kind)
      KIND_TICK: begin
        if (st.press_active && (32'(st.press_elapsed) < TIMER_MAX)) begin
          st_nxt.press_elapsed = st.press_elapsed + 1'b1;
        end
        if (st.mode == MODE_AWAKE && st.store_pending) begin
          if (st.store_countdown == '0) begin
            st_nxt.store_pending = 1'b0;
            strobe               = 1'b1;
          end else begin
            st_nxt.store_countdown = st.store_countdown - 1'b1;
          end
        end
      end
      KIND_STEP: begin
        if (st.mode == MODE_AWAKE && nv != st.level) begin
          st_nxt.level           = nv;
          st_nxt.store_pending   = 1'b1;
          st_nxt.store_countdown = load_delay(cfg.store_delay_ms);
        end
      end
      KIND_SWITCH: begin
        unique case (st.mode)
          MODE_AWAKE: begin
            if (switch_level == SW_PRESSED) begin
              st_nxt.press_active  = 1'b1;
              st_nxt.press_elapsed = '0;
            end else if (long_press) begin
              st_nxt.press_active  = 1'b0;
              st_nxt.press_elapsed = '0;
              st_nxt.store_pending = 1'b0;
              strobe               = 1'b1;
              st_nxt.mode          = MODE_ASLEEP;
            end
          end
          MODE_ASLEEP: begin
            if (switch_level == SW_PRESSED) begin
              if (st.level < cfg.wake_floor_level) begin
                st_nxt.level = cfg.wake_floor_level;
              end
              st_nxt.press_active  = 1'b0;
              st_nxt.press_elapsed = '0;
              st_nxt.release_ok    = 1'b1;
              st_nxt.mode          = MODE_WAKING;
            end
          end
          MODE_WAKING: begin
            if (switch_level == SW_PRESSED) begin
              st_nxt.press_active  = 1'b1;
              st_nxt.press_elapsed = '0;
              st_nxt.release_ok    = 1'b0;
            end else begin
              if (long_press) begin
                st_nxt.press_active  = 1'b0;
                st_nxt.press_elapsed = '0;
                st_nxt.release_ok    = 1'b1;
              end
              if (long_press || st.release_ok) begin
                st_nxt.press_active    = 1'b0;
                st_nxt.press_elapsed   = '0;
                st_nxt.mode            = MODE_AWAKE;
                st_nxt.store_pending   = 1'b1;
                st_nxt.store_countdown = load_delay(cfg.store_delay_ms);
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    // Result reflects the state after this transaction
    sleeping         = (st_nxt.mode == MODE_ASLEEP);
    boost            = !sleeping && ({1'b0, st_nxt.level} >= cfg.turbo_threshold);
    res.main_duty    = sleeping ? 8'd0 : st_nxt.level;
    res.boost_enable = boost;
    res.boost_duty   = boost ? st_nxt.level : 8'd0;
    res.asleep       = sleeping;
    res.store_strobe = strobe;
    res.store_value  = strobe ? st_nxt.level : 8'd0;
  end

endmodule

`default_nettype wire

/* rtl/core/led_dimmer_sleep_controller_top.sv */
// led_dimmer_sleep_controller_top: LED dimmer with encoder, press-to-sleep and store strobe.
// Depends on ldsc_pkg and ldsc_step.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    kind, steps, switch_level
//   out_     output     out_valid/out_ready  duties, boost, asleep, store strobe/value
//   cfg_     input      cfg_wr_en            cfg_index, cfg_data (write only)
//
// One transaction per cycle sustained while out_ready holds high; from acceptance each one
// passes the input register, then the result register. The state update for a transaction
// happens as it moves from the input register into the result register.
// Reset (rst_n low, synchronous) restores the register defaults and the power-on state.
// A stalled result register holds; the input register still accepts while it is empty.
`default_nettype none

module led_dimmer_sleep_controller_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_kind,
  input  logic signed [7:0]                   in_steps,
  input  logic                                in_switch_level,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_main_duty,
  output logic                                out_boost_enable,
  output logic [7:0]                          out_boost_duty,
  output logic                                out_asleep,
  output logic                                out_store_strobe,
  output logic [7:0]                          out_store_value,
  input  logic                                cfg_wr_en,
  input  logic [ldsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ldsc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ldsc_pkg::*;

  // Configuration registers. start_level only matters at reset, where it is
  // restored to its default anyway, so writes to it are taken and dropped.
  cfg_t   cfg_r;

  // Input register
  logic              s1_valid_r;
  logic [1:0]        s1_kind_r;
  logic signed [7:0] s1_steps_r;
  logic              s1_sw_r;

  // Lamp state
  state_t st_r;
  state_t st_nxt;
  res_t   res_nxt;

  // Result register
  logic   out_valid_r;
  res_t   out_r;

  logic   out_free;
  logic   s1_adv;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || s1_adv;

  ldsc_step u_step (
    .cfg          (cfg_r),
    .st           (st_r),
    .kind         (s1_kind_r),
    .steps        (s1_steps_r),
    .switch_level (s1_sw_r),
    .st_nxt       (st_nxt),
    .res          (res_nxt)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_level        <= RST_MAX_LEVEL;
      cfg_r.min_level        <= RST_MIN_LEVEL;
      cfg_r.turbo_threshold  <= RST_TURBO;
      cfg_r.debounce_time    <= RST_DEBOUNCE;
      cfg_r.wake_floor_level <= RST_WAKE_FLOOR;
      cfg_r.store_delay_ms   <= RST_STORE_DELAY;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MAX_LEVEL:   cfg_r.max_level        <= cfg_data[7:0];
        CFG_MIN_LEVEL:   cfg_r.min_level        <= cfg_data[7:0];
        CFG_TURBO:       cfg_r.turbo_threshold  <= cfg_data[8:0];
        CFG_DEBOUNCE:    cfg_r.debounce_time    <= cfg_data[15:0];
        CFG_WAKE_FLOOR:  cfg_r.wake_floor_level <= cfg_data[7:0];
        CFG_STORE_DELAY: cfg_r.store_delay_ms   <= cfg_data[15:0];
        CFG_START_LEVEL: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Input register: load on accept, drop when the transaction advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r  <= in_kind;
      s1_steps_r <= in_steps;
      s1_sw_r    <= in_switch_level;
    end
  end

  // Lamp state: advance once per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode            <= MODE_AWAKE;
      st_r.level           <= RST_LEVEL;
      st_r.press_active    <= 1'b0;
      st_r.press_elapsed   <= '0;
      st_r.release_ok      <= 1'b1;
      st_r.store_pending   <= 1'b1;
      st_r.store_countdown <= RST_COUNTDOWN;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_main_duty    = out_r.main_duty;
  assign out_boost_enable = out_r.boost_enable;
  assign out_boost_duty   = out_r.boost_duty;
  assign out_asleep       = out_r.asleep;
  assign out_store_strobe = out_r.store_strobe;
  assign out_store_value  = out_r.store_value;

`ifndef SYNTHESIS
  // State changes only when a transaction moves through the step logic
  a_state_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(st_r))
    else $error("lamp state changed without a transaction");

  // Asleep means no press is being timed
  a_asleep_no_press: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.mode == MODE_ASLEEP) |-> (!st_r.press_active && st_r.press_elapsed == '0))
    else $error("press timer active while asleep");

  // A stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !s1_adv)
    else $error("result register overwritten while stalled");

  // A sleeping lamp shows no light on either channel
  a_dark_when_asleep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.asleep) |-> (out_r.main_duty == 8'd0 && !out_r.boost_enable))
    else $error("light driven while asleep");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_led_dimmer_sleep_controller_top.sv */
// Self-checking testbench for led_dimmer_sleep_controller_top: directed and random traffic
// against a cycle-free behavioral predictor of the dimmer. Depends on ldsc_pkg and the RTL.
module tb_led_dimmer_sleep_controller_top;
  import ldsc_pkg::*;

  // Kind code the block must ignore, and the released switch level
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam logic       SW_RELEASED  = 1'b1;

  localparam int STALL_LIMIT = 20000;  // cycles without any transaction before giving up
  localparam int HOLD_CYCLES = 150;    // length of the forced receiver hold-off
  localparam int MAX_REPORTS = 50;     // mismatch lines printed before going silent

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_kind;
  logic signed [7:0]     in_steps;
  logic                  in_switch_level;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_main_duty;
  logic                  out_boost_enable;
  logic [7:0]            out_boost_duty;
  logic                  out_asleep;
  logic                  out_store_strobe;
  logic [7:0]            out_store_value;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  led_dimmer_sleep_controller_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_steps         (in_steps),
    .in_switch_level  (in_switch_level),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_main_duty    (out_main_duty),
    .out_boost_enable (out_boost_enable),
    .out_boost_duty   (out_boost_duty),
    .out_asleep       (out_asleep),
    .out_store_strobe (out_store_strobe),
    .out_store_value  (out_store_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predicted lamp state and its copy of the registers
  // ---------------------------------------------------------------------------
  logic [7:0]         lim_max;
  logic [7:0]         lim_min;
  logic [8:0]         turbo_at;
  logic [15:0]        debounce_len;
  logic [7:0]         floor_level;
  logic [15:0]        save_delay;
  logic [7:0]         boot_level;

  mode_t              lamp_mode;
  logic [7:0]         lamp_level;
  logic               press_on;
  logic [TIMER_W-1:0] press_ms;
  logic               release_clean;
  logic               save_pending;
  logic [TIMER_W-1:0] save_count;

  // Results still owed by the block, oldest first
  res_t owed_results[$];

  int  err_count;
  int  items_sent;
  int  results_seen;
  int  strobes_seen;
  int  sleep_results;
  int  settings_used;
  int  idle_cycles;
  bit  tx_quiet;        // sender inserts no gaps while set
  logic rx_quiet;       // receiver never stalls at random while set
  int  holds_asked;     // bumped to request one long receiver hold-off
  int  holds_done;
  int  stall_left;

  // Restart the deferred save with the delay saturated to the counter range
  function automatic void arm_save();
    save_pending = 1'b1;
    save_count = (32'(save_delay) > TIMER_MAX) ? TIMER_W'(TIMER_MAX) : TIMER_W'(save_delay);
  endfunction

  function automatic logic press_counts();
    return press_on && (32'(press_ms) > 32'(debounce_len));
  endfunction

  // Advance the lamp by one input transaction and return the result it shows
  function automatic res_t lamp_advance(input logic [1:0] kind, input logic signed [7:0] steps,
                                        input logic sw);
    res_t r;
    logic strobe;
    logic sleeping;
    logic boost;
    int   pos;
    logic [7:0] nv;
    strobe = 1'b0;
    if (kind == KIND_TICK) begin
      if (press_on && 32'(press_ms) < TIMER_MAX) press_ms = press_ms + 1'b1;
      if (lamp_mode == MODE_AWAKE && save_pending) begin
        if (save_count == '0) begin
          save_pending = 1'b0;
          strobe = 1'b1;
        end else begin
          save_count = save_count - 1'b1;
        end
      end
    end else if (kind == KIND_STEP) begin
      if (lamp_mode == MODE_AWAKE) begin
        pos = int'(lamp_level) + int'(steps);
        // The upper clamp wins first; any negative position lands on the minimum
        if (pos > int'(lim_max)) nv = lim_max;
        else if (pos < 0) nv = lim_min;
        else nv = 8'(pos);
        if (nv != lamp_level) begin
          lamp_level = nv;
          arm_save();
        end
      end
    end else if (kind == KIND_SWITCH) begin
      if (lamp_mode == MODE_AWAKE) begin
        if (sw == SW_PRESSED) begin
          press_on = 1'b1;
          press_ms = '0;
        end else if (press_counts()) begin
          press_on = 1'b0;
          press_ms = '0;
          save_pending = 1'b0;
          strobe = 1'b1;
          lamp_mode = MODE_ASLEEP;
        end
      end else if (lamp_mode == MODE_ASLEEP) begin
        if (sw == SW_PRESSED) begin
          if (lamp_level < floor_level) lamp_level = floor_level;
          press_on = 1'b0;
          press_ms = '0;
          release_clean = 1'b1;
          lamp_mode = MODE_WAKING;
        end
      end else begin
        if (sw == SW_PRESSED) begin
          press_on = 1'b1;
          press_ms = '0;
          release_clean = 1'b0;
        end else begin
          if (press_counts()) begin
            press_on = 1'b0;
            press_ms = '0;
            release_clean = 1'b1;
          end
          if (release_clean) begin
            press_on = 1'b0;
            press_ms = '0;
            lamp_mode = MODE_AWAKE;
            arm_save();
          end
        end
      end
    end
    sleeping = (lamp_mode == MODE_ASLEEP);
    boost = !sleeping && ({1'b0, lamp_level} >= turbo_at);
    r.main_duty    = sleeping ? 8'd0 : lamp_level;
    r.boost_enable = boost;
    r.boost_duty   = boost ? lamp_level : 8'd0;
    r.asleep       = sleeping;
    r.store_strobe = strobe;
    r.store_value  = strobe ? lamp_level : 8'd0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off per request, counted here
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
      holds_done = 0;
    end else if (holds_done != holds_asked) begin
      holds_done = holds_asked;
      stall_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (!rx_quiet && $urandom_range(0, 99) < 20) begin
      // Mostly short stalls, now and then a long one
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void compare_field(input string name, input logic [8:0] want,
                                        input logic [8:0] got);
    if (got !== want) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Check every result transaction against the oldest owed result
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_store_strobe === 1'b1) strobes_seen++;
      if (out_asleep === 1'b1) sleep_results++;
      if (owed_results.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: result transaction with nothing expected, actual duty %0d", $time,
                   out_main_duty);
      end else begin
        want = owed_results.pop_front();
        compare_field("main_duty", want.main_duty, out_main_duty);
        compare_field("boost_enable", want.boost_enable, out_boost_enable);
        compare_field("boost_duty", want.boost_duty, out_boost_duty);
        compare_field("asleep", want.asleep, out_asleep);
        compare_field("store_strobe", want.store_strobe, out_store_strobe);
        compare_field("store_value", want.store_value, out_store_value);
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (tx_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one input transaction, hold it until accepted, then predict its result.
  // Valid is left high on return; the next send or drain_results settles it.
  task automatic send_item(input logic [1:0] kind, input logic signed [7:0] steps,
                           input logic sw);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_steps        <= steps;
    in_switch_level <= sw;
    do @(posedge clk); while (!in_ready);
    owed_results.push_back(lamp_advance(kind, steps, sw));
    items_sent++;
  endtask

  task automatic tick(input int n);
    for (int i = 0; i < n; i++) send_item(KIND_TICK, 8'($urandom), 1'($urandom));
  endtask

  task automatic step(input logic signed [7:0] d);
    send_item(KIND_STEP, d, 1'($urandom));
  endtask

  task automatic switch_to(input logic sw);
    send_item(KIND_SWITCH, 8'($urandom), sw);
  endtask

  // Drop valid, wait until every owed result has come, then let the block sit idle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_MAX_LEVEL:   lim_max = value[7:0];
      CFG_MIN_LEVEL:   lim_min = value[7:0];
      CFG_TURBO:       turbo_at = value[8:0];
      CFG_DEBOUNCE:    debounce_len = value;
      CFG_WAKE_FLOOR:  floor_level = value[7:0];
      CFG_STORE_DELAY: save_delay = value;
      CFG_START_LEVEL: boot_level = value[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Load a full setting while the block is idle
  task automatic program_lamp(input logic [7:0] mx, input logic [7:0] mn,
                              input logic [8:0] turbo, input logic [15:0] deb,
                              input logic [7:0] floor_lvl, input logic [15:0] delay);
    reg_write(CFG_MAX_LEVEL, 16'(mx));
    reg_write(CFG_MIN_LEVEL, 16'(mn));
    reg_write(CFG_TURBO, 16'(turbo));
    reg_write(CFG_DEBOUNCE, deb);
    reg_write(CFG_WAKE_FLOOR, 16'(floor_lvl));
    reg_write(CFG_STORE_DELAY, delay);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Power-on level and defaults, step extremes, ignored inputs
  task automatic test_power_on();
    tick(2);
    step(8'sd127);
    step(8'sd127);
    step(-8'sd128);
    step(8'sd0);
    switch_to(SW_RELEASED);   // release with no press before it
    send_item(KIND_UNKNOWN, 8'($urandom), 1'($urandom));
    send_item(KIND_UNKNOWN, 8'hff, 1'b0);
    tick(1);
    drain_results();
  endtask

  // Upper clamp, negative positions, minimum above maximum, turbo extremes
  task automatic test_clamp_limits();
    program_lamp(8'd200, 8'd30, 9'd256, 16'd50, 8'd10, 16'd3500);
    step(8'sd127);
    step(8'sd127);
    step(-8'sd128);
    step(-8'sd128);
    step(-8'sd128);
    drain_results();
    program_lamp(8'd5, 8'd250, 9'd0, 16'd50, 8'd10, 16'd3500);
    step(-8'sd128);
    step(8'sd1);
    step(-8'sd5);
    tick(1);
    drain_results();
  endtask

  // Deferred save: zero delay, short delay, and a step that changes nothing
  task automatic test_store_strobe();
    program_lamp(8'd255, 8'd0, 9'd128, 16'd50, 8'd10, 16'd0);
    tick(2);
    step(8'sd3);
    tick(2);
    drain_results();
    program_lamp(8'd255, 8'd0, 9'd128, 16'd50, 8'd10, 16'd3);
    step(8'sd1);
    tick(5);
    step(8'sd127);
    step(8'sd127);
    tick(5);
    step(8'sd1);       // already at the top: no new save armed
    tick(5);
    drain_results();
  endtask

  // Sleep entry, ignored inputs while asleep, waking and its release rules
  task automatic test_sleep_and_wake();
    program_lamp(8'd255, 8'd0, 9'd128, 16'd2, 8'd40, 16'd5);
    step(-8'sd128);
    step(-8'sd128);
    switch_to(SW_PRESSED);
    tick(3);
    switch_to(SW_RELEASED);
    tick(2);
    step(8'sd10);
    switch_to(SW_RELEASED);
    switch_to(SW_PRESSED);   // wake at the floor
    step(8'sd5);             // ignored while waking
    switch_to(SW_RELEASED);
    switch_to(SW_PRESSED);
    tick(3);
    switch_to(SW_RELEASED);
    switch_to(SW_PRESSED);
    switch_to(SW_PRESSED);   // second press while waking blocks the release
    switch_to(SW_RELEASED);
    tick(3);
    switch_to(SW_RELEASED);
    // A short release keeps the press timer running; a later release counts
    switch_to(SW_PRESSED);
    tick(1);
    switch_to(SW_RELEASED);
    tick(2);
    switch_to(SW_RELEASED);
    switch_to(SW_PRESSED);
    switch_to(SW_RELEASED);
    drain_results();
    program_lamp(8'd255, 8'd0, 9'd128, 16'd0, 8'd40, 16'd5);
    switch_to(SW_PRESSED);
    switch_to(SW_RELEASED);  // zero-length press never counts
    tick(1);
    switch_to(SW_RELEASED);
    switch_to(SW_PRESSED);
    switch_to(SW_RELEASED);
    tick(8);
    drain_results();
  endtask

  // A start level written after reset must not move the live level
  task automatic test_late_start_level();
    reg_write(CFG_START_LEVEL, 16'd3);
    cfg_wr_en <= 1'b0;
    program_lamp(8'd255, 8'd0, 9'd128, 16'd2, 8'd200, 16'd5);
    tick(2);
    step(-8'sd128);
    step(-8'sd128);
    switch_to(SW_PRESSED);
    tick(3);
    switch_to(SW_RELEASED);
    switch_to(SW_PRESSED);
    switch_to(SW_RELEASED);
    tick(8);
    drain_results();
  endtask

  // Largest debounce and delay: a short press never counts and no save fires
  task automatic test_timer_limits();
    program_lamp(8'd255, 8'd0, 9'd128, 16'hffff, 8'd10, 16'hffff);
    tx_quiet = 1'b1;
    rx_quiet <= 1'b1;
    step(-8'sd1);
    switch_to(SW_PRESSED);
    tick(40);
    switch_to(SW_RELEASED);
    tick(1);
    tx_quiet = 1'b0;
    rx_quiet <= 1'b0;
    drain_results();
  endtask

  // Receiver holds off while the sender keeps offering, then the sender waits it out
  task automatic test_backpressure();
    program_lamp(8'd255, 8'd0, 9'd100, 16'd3, 8'd10, 16'd4);
    holds_asked <= holds_asked + 1;
    tx_quiet = 1'b1;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 0) step(8'($urandom_range(0, 15)) - 8'sd7);
      else tick(1);
    end
    tx_quiet = 1'b0;
    drain_results();
  endtask

  // Random traffic over several settings, mostly well-formed press sequences
  task automatic test_random_traffic();
    int start_count;
    int r;
    int cap;
    logic signed [7:0] d;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0)
        program_lamp(8'd255, 8'd0, 9'd256, 16'd0, 8'd255, 16'd0);
      else if (ph == 5)
        program_lamp(8'd0, 8'd255, 9'd0, 16'hffff, 8'd0, 16'hffff);
      else
        program_lamp(8'($urandom_range(0, 255)), 8'($urandom_range(0, 60)),
                     9'($urandom_range(0, 256)), 16'($urandom_range(0, 12)),
                     8'($urandom_range(0, 255)), 16'($urandom_range(0, 30)));
      // One phase runs with no idling on either side
      tx_quiet = (ph == 2);
      rx_quiet <= (ph == 2);
      start_count = items_sent;
      while (items_sent - start_count < 300) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          tick(1);
        end else if (r < 55) begin
          if ($urandom_range(0, 3) == 0) begin
            d = 8'($urandom);
          end else begin
            d = 8'($urandom_range(1, 8));
            if ($urandom_range(0, 1) == 1) d = -d;
          end
          step(d);
        end else if (r < 78) begin
          // Press, hold around the debounce time, release
          cap = (debounce_len > 16'd20) ? 20 : int'(debounce_len);
          switch_to(SW_PRESSED);
          tick($urandom_range(0, cap + 3));
          switch_to(SW_RELEASED);
        end else if (r < 88) begin
          switch_to(1'($urandom));
        end else if (r < 92) begin
          send_item(KIND_UNKNOWN, 8'($urandom), 1'($urandom));
        end else begin
          cap = (save_delay > 16'd40) ? 40 : int'(save_delay);
          tick($urandom_range(1, cap + 2));
        end
      end
      tx_quiet = 1'b0;
      rx_quiet <= 1'b0;
      drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_kind         <= KIND_TICK;
    in_steps        <= 8'sd0;
    in_switch_level <= SW_RELEASED;
    cfg_wr_en       <= 1'b0;
    cfg_index       <= CFG_MAX_LEVEL;
    cfg_data        <= '0;
    rx_quiet        <= 1'b0;
    holds_asked     <= 0;
    tx_quiet      = 1'b0;
    err_count     = 0;
    items_sent    = 0;
    results_seen  = 0;
    strobes_seen  = 0;
    sleep_results = 0;
    settings_used = 0;
    idle_cycles   = 0;

    // Power-on register values and lamp state
    lim_max       = RST_MAX_LEVEL;
    lim_min       = RST_MIN_LEVEL;
    turbo_at      = RST_TURBO;
    debounce_len  = RST_DEBOUNCE;
    floor_level   = RST_WAKE_FLOOR;
    save_delay    = RST_STORE_DELAY;
    boot_level    = RST_START_LEVEL;
    lamp_mode     = MODE_AWAKE;
    lamp_level    = (boot_level < floor_level) ? floor_level : boot_level;
    press_on      = 1'b0;
    press_ms      = '0;
    release_clean = 1'b1;
    arm_save();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_power_on();
    test_clamp_limits();
    test_store_strobe();
    test_sleep_and_wake();
    test_late_start_level();
    test_timer_limits();
    test_backpressure();
    test_random_traffic();

    if (owed_results.size() != 0) begin
      err_count++;
      $display("%0t: %0d expected results never arrived", $time, owed_results.size());
    end
    $display("Sent %0d input transactions over %0d register settings; checked %0d results.",
             items_sent, settings_used, results_seen);
    $display("Results showed %0d store strobes and %0d asleep outputs; %0d mismatches.",
             strobes_seen, sleep_results, err_count);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
